/* design/ils_pkg.sv */
// ----------------------------------------------------------------------------
// Indicator lamp sequencer package
// Shared types, phase codes, register indexes and lamp masks.
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int unsigned PHASE_W = 4;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned DELAY_W = 16;
    localparam int unsigned LAMP_W  = 9;
    localparam int unsigned CFG_IDX_W = 2;

    // Sequencer phases
    localparam logic [PHASE_W-1:0] PH_OFF        = 4'd0;
    localparam logic [PHASE_W-1:0] PH_PWR_WAIT   = 4'd1;
    localparam logic [PHASE_W-1:0] PH_PWR_BLINK  = 4'd2;
    localparam logic [PHASE_W-1:0] PH_POWERED    = 4'd3;
    localparam logic [PHASE_W-1:0] PH_UNLOCKED   = 4'd4;
    localparam logic [PHASE_W-1:0] PH_BRK_CLOSED = 4'd5;
    localparam logic [PHASE_W-1:0] PH_LOCK_WAIT  = 4'd6;
    localparam logic [PHASE_W-1:0] PH_LAMP_WAIT  = 4'd7;
    localparam logic [PHASE_W-1:0] PH_LOCKED     = 4'd8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_READY_DELAY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOCKING       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BRK_LAMP_OFF  = 2'd3;

    localparam logic [DELAY_W-1:0] READY_DELAY_RST  = 16'd2000;
    localparam logic [DELAY_W-1:0] BLINK_RST        = 16'd200;
    localparam logic [DELAY_W-1:0] LOCKING_RST      = 16'd1000;
    localparam logic [DELAY_W-1:0] BRK_LAMP_OFF_RST = 16'd200;

    // Lamp masks, bit 0 is the breaker lamp
    localparam logic [LAMP_W-1:0] MASK_NONE    = 9'h000;
    localparam logic [LAMP_W-1:0] MASK_BREAKER = 9'h001;
    localparam logic [LAMP_W-1:0] MASK_POWERUP = 9'h043;
    localparam logic [LAMP_W-1:0] MASK_READY   = 9'h003;
    localparam logic [LAMP_W-1:0] MASK_ALL     = 9'h1FF;
    localparam logic [LAMP_W-1:0] MASK_CLOSED  = 9'h02B;
    localparam logic [LAMP_W-1:0] MASK_LOCKED  = 9'h002;

    typedef struct packed {
        logic [DELAY_W-1:0] ready_delay_ms;
        logic [DELAY_W-1:0] blink_ms;
        logic [DELAY_W-1:0] locking_ms;
        logic [DELAY_W-1:0] breaker_lamp_off_ms;
    } cfg_t;

    typedef struct packed {
        logic               breaker_locked;
        logic               breaker_closed;
        logic               panel_unlocked;
        logic               battery_closed;
        logic [TIME_W-1:0]  now_ms;
    } item_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [TIME_W-1:0]  start_ms;
        logic               emit;
        logic [LAMP_W-1:0]  lamp_mask;
    } step_t;

endpackage

/* design/ils_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Indicator lamp sequencer configuration registers
// Holds the four delay settings, written through a plain write port.
// ----------------------------------------------------------------------------
module ils_cfg_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ils_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ils_pkg::DELAY_W-1:0]     cfg_wdata,
    output ils_pkg::cfg_t                   cfg
);

    ils_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ready_delay_ms      <= ils_pkg::READY_DELAY_RST;
            cfg_reg.blink_ms            <= ils_pkg::BLINK_RST;
            cfg_reg.locking_ms          <= ils_pkg::LOCKING_RST;
            cfg_reg.breaker_lamp_off_ms <= ils_pkg::BRK_LAMP_OFF_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ils_pkg::REG_READY_DELAY:  cfg_reg.ready_delay_ms      <= cfg_wdata;
                ils_pkg::REG_BLINK:        cfg_reg.blink_ms            <= cfg_wdata;
                ils_pkg::REG_LOCKING:      cfg_reg.locking_ms          <= cfg_wdata;
                ils_pkg::REG_BRK_LAMP_OFF: cfg_reg.breaker_lamp_off_ms <= cfg_wdata;
                default:                   cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/ils_step_logic.sv */
// ----------------------------------------------------------------------------
// Indicator lamp sequencer step logic
// Next phase, phase start time and lamp update for one registered item.
// ----------------------------------------------------------------------------
module ils_step_logic
(
    input  logic [ils_pkg::PHASE_W-1:0] phase,
    input  logic [ils_pkg::TIME_W-1:0]  start_ms,
    input  ils_pkg::cfg_t               cfg,
    input  ils_pkg::item_t              item,
    output ils_pkg::step_t              step
);

    logic [ils_pkg::DELAY_W-1:0] delay;
    logic [ils_pkg::TIME_W-1:0]  deadline;
    logic                        elapsed;

    // Only one timed phase is active at a time, so one adder serves all.
    always_comb
    begin
        case (phase)
            ils_pkg::PH_PWR_WAIT:  delay = cfg.ready_delay_ms;
            ils_pkg::PH_PWR_BLINK: delay = cfg.blink_ms;
            ils_pkg::PH_LOCK_WAIT: delay = cfg.locking_ms;
            default:               delay = cfg.breaker_lamp_off_ms;
        endcase
    end

    assign deadline = start_ms + {{(ils_pkg::TIME_W-ils_pkg::DELAY_W){1'b0}}, delay};
    assign elapsed  = item.now_ms > deadline;

    always_comb
    begin
        step.phase     = phase;
        step.start_ms  = start_ms;
        step.emit      = 1'b0;
        step.lamp_mask = ils_pkg::MASK_NONE;

        unique case (phase)
            ils_pkg::PH_OFF:
            begin
                if (item.battery_closed)
                begin
                    step.emit      = 1'b1;
                    step.lamp_mask = ils_pkg::MASK_BREAKER;
                    step.start_ms  = item.now_ms;
                    step.phase     = ils_pkg::PH_PWR_WAIT;
                end
            end
            ils_pkg::PH_PWR_WAIT:
            begin
                if (!item.battery_closed)
                begin
                    step.emit  = 1'b1;
                    step.phase = ils_pkg::PH_OFF;
                end
                else if (elapsed)
                begin
                    step.emit      = 1'b1;
                    step.lamp_mask = ils_pkg::MASK_POWERUP;
                    step.start_ms  = item.now_ms;
                    step.phase     = ils_pkg::PH_PWR_BLINK;
                end
            end
            ils_pkg::PH_PWR_BLINK:
            begin
                if (!item.battery_closed)
                begin
                    step.emit  = 1'b1;
                    step.phase = ils_pkg::PH_OFF;
                end
                else if (elapsed)
                begin
                    step.emit      = 1'b1;
                    step.lamp_mask = ils_pkg::MASK_READY;
                    step.phase     = ils_pkg::PH_POWERED;
                end
            end
            ils_pkg::PH_POWERED:
            begin
                if (!item.battery_closed)
                begin
                    step.emit  = 1'b1;
                    step.phase = ils_pkg::PH_OFF;
                end
                else if (item.panel_unlocked)
                begin
                    step.emit      = 1'b1;
                    step.lamp_mask = ils_pkg::MASK_ALL;
                    step.phase     = ils_pkg::PH_UNLOCKED;
                end
            end
            ils_pkg::PH_UNLOCKED:
            begin
                if (!item.battery_closed)
                begin
                    step.emit  = 1'b1;
                    step.phase = ils_pkg::PH_OFF;
                end
                else if (!item.panel_unlocked)
                begin
                    step.emit      = 1'b1;
                    step.lamp_mask = ils_pkg::MASK_READY;
                    step.phase     = ils_pkg::PH_POWERED;
                end
                else if (item.breaker_closed)
                begin
                    step.emit      = 1'b1;
                    step.lamp_mask = ils_pkg::MASK_CLOSED;
                    step.phase     = ils_pkg::PH_BRK_CLOSED;
                end
            end
            ils_pkg::PH_BRK_CLOSED:
            begin
                if (!item.battery_closed)
                begin
                    step.emit  = 1'b1;
                    step.phase = ils_pkg::PH_OFF;
                end
                else if (!item.breaker_closed)
                begin
                    step.emit      = 1'b1;
                    step.lamp_mask = ils_pkg::MASK_ALL;
                    step.phase     = ils_pkg::PH_UNLOCKED;
                end
                else if (item.breaker_locked)
                begin
                    // Locking starts without a lamp update.
                    step.start_ms = item.now_ms;
                    step.phase    = ils_pkg::PH_LOCK_WAIT;
                end
            end
            ils_pkg::PH_LOCK_WAIT:
            begin
                // The battery switch is ignored while the breaker locks.
                if (elapsed)
                begin
                    step.emit      = 1'b1;
                    step.lamp_mask = ils_pkg::MASK_READY;
                    step.start_ms  = item.now_ms;
                    step.phase     = ils_pkg::PH_LAMP_WAIT;
                end
            end
            ils_pkg::PH_LAMP_WAIT:
            begin
                if (elapsed)
                begin
                    step.emit      = 1'b1;
                    step.lamp_mask = ils_pkg::MASK_LOCKED;
                    step.phase     = ils_pkg::PH_LOCKED;
                end
            end
            ils_pkg::PH_LOCKED:
            begin
                if (!item.battery_closed)
                begin
                    step.emit  = 1'b1;
                    step.phase = ils_pkg::PH_OFF;
                end
                else if (!item.breaker_closed)
                begin
                    step.emit      = 1'b1;
                    step.lamp_mask = ils_pkg::MASK_ALL;
                    step.phase     = ils_pkg::PH_UNLOCKED;
                end
            end
            default:
            begin
                step.phase = ils_pkg::PH_OFF;
            end
        endcase
    end

endmodule

/* design/indicator_lamp_sequencer_top.sv */
// ----------------------------------------------------------------------------
// Indicator lamp sequencer top level
// Cab lamp sequencer: one switch/time beat in, at most one lamp mask out.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tdata: now_ms[31:0], battery_closed, panel_unlocked,
//                       breaker_closed, breaker_locked (40 bits)
//  m_axis    out        tdata: lamp_mask[8:0] (16 bits)
//  cfg       in         write enable, register index, 16-bit data
//
//  Each beat sits in the input register while the step logic works on it;
//  its lamp update (if any) is registered when the step fires. A new beat
//  is taken each cycle unless the output stalls; phase_reg closes the loop.
//  A stalled output holds the step stage only while a result waits in the
//  output register; reset returns to the off phase with default delays.
// ----------------------------------------------------------------------------
module indicator_lamp_sequencer_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // now_ms, battery_closed, panel_unlocked,
                                   // breaker_closed, breaker_locked, zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // lamp_mask, zeros
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    ils_pkg::cfg_t                cfg;
    ils_pkg::item_t               item_reg;
    logic                         in_valid_reg;
    logic [ils_pkg::PHASE_W-1:0]  phase_reg;
    logic [ils_pkg::TIME_W-1:0]   start_reg;
    logic                         out_valid_reg;
    logic [ils_pkg::LAMP_W-1:0]   lamp_reg;
    ils_pkg::step_t               step;
    logic                         out_free;
    logic                         step_fire;

    ils_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ils_step_logic u_step
    (
        .phase    (phase_reg),
        .start_ms (start_reg),
        .cfg      (cfg),
        .item     (item_reg),
        .step     (step)
    );

    assign out_free  = !out_valid_reg || m_tready;
    assign step_fire = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || step_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= ils_pkg::PH_OFF;
            start_reg     <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (step_fire)
            begin
                out_valid_reg <= step.emit;
                phase_reg     <= step.phase;
                start_reg     <= step.start_ms;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg <= s_tdata[35:0];
        end
        if (step_fire && step.emit)
        begin
            lamp_reg <= step.lamp_mask;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(16-ils_pkg::LAMP_W){1'b0}}, lamp_reg};

    // Only the nine defined phases are ever stored.
    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= ils_pkg::PH_LOCKED)
        else $error("phase register holds an undefined code");

    // Turning the battery on from off lights the breaker lamp next cycle.
    a_power_on: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && phase_reg == ils_pkg::PH_OFF && item_reg.battery_closed
        |=> m_tvalid && m_tdata[8:0] == ils_pkg::MASK_BREAKER)
        else $error("power-on beat did not show the breaker lamp");

    // Any drop back to off shows all lamps dark.
    a_drop_off: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && phase_reg != ils_pkg::PH_OFF && step.phase == ils_pkg::PH_OFF
        |=> m_tvalid && m_tdata[8:0] == ils_pkg::MASK_NONE)
        else $error("drop to off did not clear the lamps");

    // Locking starts silently and the start time follows the beat.
    a_lock_start: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && phase_reg == ils_pkg::PH_BRK_CLOSED
        && step.phase == ils_pkg::PH_LOCK_WAIT
        |=> !m_tvalid && start_reg == $past(item_reg.now_ms))
        else $error("locking start produced a beat or lost its start time");

    // An empty input register never blocks the slave side.
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stalled with an empty input register");

endmodule
